/* rtl/mlc_pkg.sv */
// Shared types, constants and the sigmoid table of the minLSTM recurrent cell.
// Depends on nothing; every other file of the block imports it.
package mlc_pkg;

    localparam int ACC_W      = 40;
    localparam int FRAC       = 12;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int MODE_W     = 2;
    localparam int GATE_W     = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int UNIT_W     = 6;
    localparam int SIG_W      = 16;
    localparam int SIG_LAST   = 16;

    localparam int DEF_MAX_INPUT  = 64;
    localparam int DEF_MAX_HIDDEN = 64;
    localparam int DEF_DATA_WIDTH = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_COUNT = 1'd1;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ELEM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [GATE_W-1:0] GATE_FORGET = 2'd0;
    localparam logic [GATE_W-1:0] GATE_INPUT  = 2'd1;
    localparam logic [GATE_W-1:0] GATE_CAND   = 2'd2;

    localparam logic [SIG_W-1:0] SIG_TAB [SIG_LAST+1] = '{
        16'd16384, 16'd20397, 16'd23955, 16'd26790, 16'd28862, 16'd30282,
        16'd31214, 16'd31807, 16'd32179, 16'd32408, 16'd32549, 16'd32635,
        16'd32687, 16'd32719, 16'd32738, 16'd32750, 16'd32757
    };

    typedef struct packed {
        logic signed [ACC_W-1:0] acc_f;
        logic signed [ACC_W-1:0] acc_i;
        logic signed [ACC_W-1:0] acc_c;
    } acc_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_FRD,
        ST_FZ,
        ST_FSIG,
        ST_FMUL,
        ST_FSUM,
        ST_FDIV,
        ST_SKIP,
        ST_CLR
    } state_t;

    // Piecewise linear sigmoid in Q1.15 of a Q4.12 argument.
    function automatic logic [SIG_W-1:0] sigmoid_q15(input logic signed [15:0] z);
        logic [15:0]     a;
        logic [4:0]      idx;
        logic [SIG_W-1:0] lo;
        logic [SIG_W-1:0] hi;
        logic [SIG_W-1:0] y;
        logic [26:0]     step;
        a   = z[15] ? 16'(-z) : 16'(z);
        idx = a[15:11];
        lo  = SIG_TAB[idx];
        hi  = SIG_TAB[5'(idx + 5'd1)];
        step = 27'(hi - lo) * 27'(a[10:0]);
        if (idx >= 5'(SIG_LAST))
        begin
            y = SIG_TAB[SIG_LAST];
        end
        else
        begin
            y = lo + 16'(step >> 11);
        end
        return z[15] ? 16'(17'd32768 - 17'(y)) : y;
    endfunction

endpackage

/* rtl/mlc_cell.sv */
// One cell of the accumulator ring: three projection sums and one hidden value.
// Depends on mlc_pkg.
module mlc_cell #(
    parameter int DATA_WIDTH = mlc_pkg::DEF_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift,
    input  logic                         clear_acc,
    input  logic                         clear_h,
    input  mlc_pkg::acc_t                acc_in,
    input  logic signed [DATA_WIDTH-1:0] h_in,
    output mlc_pkg::acc_t                acc_out,
    output logic signed [DATA_WIDTH-1:0] h_out
);
    import mlc_pkg::*;

    acc_t                         acc_reg;
    logic signed [DATA_WIDTH-1:0] h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            h_reg   <= '0;
        end
        else if (shift)
        begin
            acc_reg <= acc_in;
            h_reg   <= h_in;
        end
        else
        begin
            if (clear_acc)
            begin
                acc_reg <= '0;
            end
            if (clear_h)
            begin
                h_reg <= '0;
            end
        end
    end

    assign acc_out = acc_reg;
    assign h_out   = h_reg;

endmodule

/* rtl/mlc_div.sv */
// Restoring divider, one quotient bit per cycle, for the hidden value update.
// Depends on mlc_pkg.
module mlc_div #(
    parameter int NW = 48,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    import mlc_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(NW);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cnt_reg == CW'(1);
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= fits ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/minlstm_cell_forward.sv */
// Top level of the minLSTM recurrent cell: command port, parameter memories,
// the accumulator ring of mlc_cell instances, the finish sequencer and mlc_div.
// Depends on mlc_pkg, mlc_cell and mlc_div.
//
// Channel   Direction  Handshake                Payload
// command   in         start, busy              mode, gate, is_bias, row, col, value
// result    out        result_valid (strobe)    unit_index, hidden_value, last
// config    in         cfg_we                   cfg_index, cfg_data
//
// A load or clear word leaves the block idle. An element word steps the ring once per
// hidden unit behind a two-stage weight read and multiply. The word that completes a
// vector then reads biases, rounds, takes sigmoids, multiplies, sums and divides for
// each unit in use, turns the ring past unused units and clears the sums. Reset
// clears the ring and counters, sets the configuration to one, and does not clear the
// parameter memories. Results are strobes and cannot be stalled by the receiver.
module minlstm_cell_forward #(
    parameter int MAX_INPUT  = mlc_pkg::DEF_MAX_INPUT,
    parameter int MAX_HIDDEN = mlc_pkg::DEF_MAX_HIDDEN,
    parameter int DATA_WIDTH = mlc_pkg::DEF_DATA_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [mlc_pkg::MODE_W-1:0]           mode,
    input  logic [mlc_pkg::GATE_W-1:0]           gate,
    input  logic                                 is_bias,
    input  logic [mlc_pkg::ROW_W-1:0]            row,
    input  logic [mlc_pkg::COL_W-1:0]            col,
    input  logic signed [DATA_WIDTH-1:0]         value,
    input  logic                                 cfg_we,
    input  logic [mlc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mlc_pkg::CFG_W-1:0]            cfg_data,
    output logic                                 result_valid,
    output logic [mlc_pkg::UNIT_W-1:0]           unit_index,
    output logic signed [DATA_WIDTH-1:0]         hidden_value,
    output logic                                 last
);
    import mlc_pkg::*;

    localparam int KW   = MAX_INPUT > 1 ? $clog2(MAX_INPUT) : 1;
    localparam int HW   = MAX_HIDDEN > 1 ? $clog2(MAX_HIDDEN) : 1;
    localparam int CW   = $clog2(MAX_INPUT + 1);
    localparam int JW   = $clog2(MAX_HIDDEN + 1);
    localparam int PW   = $clog2(MAX_HIDDEN + 3);
    localparam int WD   = MAX_INPUT * MAX_HIDDEN;
    localparam int WAW  = WD > 1 ? $clog2(WD) : 1;
    localparam int Z_W  = (ACC_W > DATA_WIDTH + FRAC ? ACC_W : DATA_WIDTH + FRAC) + 1;
    localparam int C_W  = Z_W - FRAC;
    localparam int S_W  = SIG_W + 1;
    localparam int P_W  = S_W + C_W;
    localparam int M_W  = P_W + 1;
    localparam int NW   = M_W + 1;
    localparam logic [NW-1:0] DMAX = NW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);

    state_t state_reg, state_next;
    logic [PW-1:0] p_reg, p_next;
    logic [JW-1:0] j_reg, j_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0] len_reg, hcount_reg;
    logic [CW-1:0] nin;
    logic [JW-1:0] nh;

    logic accept, cmd_elem, w_we, b_we;
    logic signed [DATA_WIDTH-1:0] x_reg;
    logic signed [DATA_WIDTH-1:0] w_q [3];
    logic signed [DATA_WIDTH-1:0] b_q [3];
    logic signed [2*DATA_WIDTH-1:0] prod_reg [3];
    logic w_rd;
    logic [WAW-1:0] w_rd_addr, w_wr_addr;

    acc_t acc_chain [MAX_HIDDEN];
    logic signed [DATA_WIDTH-1:0] h_chain [MAX_HIDDEN];
    acc_t wrap_acc;
    logic signed [DATA_WIDTH-1:0] wrap_h;
    logic shift, clear_acc, clear_h, add_en;

    logic signed [Z_W-1:0] zsum [3];
    logic signed [C_W-1:0] zr [3];
    logic signed [15:0] zf_reg, zi_reg;
    logic signed [C_W-1:0] zc_reg;
    logic [SIG_W-1:0] f_reg, i_reg;
    logic signed [P_W-1:0] pf_reg, pi_reg;
    logic [S_W-1:0] s_reg;
    logic signed [M_W-1:0] num;
    logic [M_W-1:0] mag;
    logic neg_reg, div_start, div_done;
    logic [NW-1:0] div_num, uq;
    logic signed [DATA_WIDTH-1:0] q_sat;

    logic out_valid_reg, out_last_reg;
    logic [UNIT_W-1:0] out_unit_reg;
    logic signed [DATA_WIDTH-1:0] out_h_reg;

    assign accept   = start && !busy;
    assign busy     = state_reg != ST_IDLE;
    assign cmd_elem = accept && mode == MODE_ELEM;
    assign clear_h  = accept && mode == MODE_CLEAR;
    assign w_we = accept && mode == MODE_LOAD && gate <= GATE_CAND && !is_bias
                  && 32'(col) < MAX_HIDDEN && 32'(row) < MAX_INPUT;
    assign b_we = accept && mode == MODE_LOAD && gate <= GATE_CAND && is_bias
                  && 32'(col) < MAX_HIDDEN;

    assign nin = len_reg == '0 ? CW'(1) :
                 (32'(len_reg) > MAX_INPUT ? CW'(MAX_INPUT) : CW'(len_reg));
    assign nh  = hcount_reg == '0 ? JW'(1) :
                 (32'(hcount_reg) > MAX_HIDDEN ? JW'(MAX_HIDDEN) : JW'(hcount_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= CFG_W'(1);
            hcount_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INPUT_LENGTH: len_reg    <= cfg_data;
                REG_HIDDEN_COUNT: hcount_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_elem)
        begin
            x_reg <= value;
        end
    end

    assign w_rd      = state_reg == ST_ACC && 32'(p_reg) < MAX_HIDDEN;
    assign w_rd_addr = WAW'(32'(cnt_reg[KW-1:0]) * MAX_HIDDEN + 32'(p_reg));
    assign w_wr_addr = WAW'(32'(row) * MAX_HIDDEN + 32'(col));

    for (genvar g = 0; g < 3; g++)
    begin : g_gate
        logic signed [DATA_WIDTH-1:0] wmem [WD];
        logic signed [DATA_WIDTH-1:0] bmem [MAX_HIDDEN];

        always_ff @(posedge clk)
        begin
            if (w_we && gate == GATE_W'(g))
            begin
                wmem[w_wr_addr] <= value;
            end
            if (w_rd)
            begin
                w_q[g] <= wmem[w_rd_addr];
            end
        end

        always_ff @(posedge clk)
        begin
            if (b_we && gate == GATE_W'(g))
            begin
                bmem[col[HW-1:0]] <= value;
            end
            if (state_reg == ST_FRD)
            begin
                b_q[g] <= bmem[j_reg[HW-1:0]];
            end
        end

        always_ff @(posedge clk)
        begin
            prod_reg[g] <= x_reg * w_q[g];
        end
    end

    for (genvar c = 0; c < MAX_HIDDEN; c++)
    begin : g_ring
        mlc_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .clear_acc(clear_acc),
            .clear_h  (clear_h),
            .acc_in   (c == MAX_HIDDEN - 1 ? wrap_acc : acc_chain[(c + 1) % MAX_HIDDEN]),
            .h_in     (c == MAX_HIDDEN - 1 ? wrap_h : h_chain[(c + 1) % MAX_HIDDEN]),
            .acc_out  (acc_chain[c]),
            .h_out    (h_chain[c])
        );
    end

    assign add_en = p_reg >= PW'(2) && 32'(p_reg) < 32'(nh) + 32'd2;

    always_comb
    begin
        wrap_acc = acc_chain[0];
        wrap_h   = h_chain[0];
        if (state_reg == ST_ACC && add_en)
        begin
            wrap_acc.acc_f = acc_chain[0].acc_f + ACC_W'(prod_reg[0]);
            wrap_acc.acc_i = acc_chain[0].acc_i + ACC_W'(prod_reg[1]);
            wrap_acc.acc_c = acc_chain[0].acc_c + ACC_W'(prod_reg[2]);
        end
        if (state_reg == ST_FDIV)
        begin
            wrap_h = q_sat;
        end
    end

    assign zsum[0] = Z_W'(acc_chain[0].acc_f) + (Z_W'(b_q[0]) <<< FRAC) + Z_W'(2048);
    assign zsum[1] = Z_W'(acc_chain[0].acc_i) + (Z_W'(b_q[1]) <<< FRAC) + Z_W'(2048);
    assign zsum[2] = Z_W'(acc_chain[0].acc_c) + (Z_W'(b_q[2]) <<< FRAC) + Z_W'(2048);

    for (genvar g = 0; g < 3; g++)
    begin : g_round
        assign zr[g] = zsum[g][Z_W-1:FRAC];
    end

    function automatic logic signed [15:0] sat16(input logic signed [C_W-1:0] v);
        if (v > C_W'(32767))
        begin
            return 16'sd32767;
        end
        else if (v < -C_W'(32768))
        begin
            return -16'sd32768;
        end
        return 16'(v);
    endfunction

    assign num     = M_W'(pf_reg) + M_W'(pi_reg);
    assign mag     = num[M_W-1] ? M_W'(-num) : M_W'(num);
    assign div_num = NW'(mag) + NW'(s_reg >> 1);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_FZ:
            begin
                zf_reg <= sat16(zr[0]);
                zi_reg <= sat16(zr[1]);
                zc_reg <= zr[2];
            end
            ST_FSIG:
            begin
                f_reg <= sigmoid_q15(zf_reg);
                i_reg <= sigmoid_q15(zi_reg);
            end
            ST_FMUL:
            begin
                pf_reg <= P_W'($signed({1'b0, f_reg}) * h_chain[0]);
                pi_reg <= P_W'($signed({1'b0, i_reg}) * zc_reg);
                s_reg  <= S_W'(f_reg) + S_W'(i_reg);
            end
            ST_FSUM:
            begin
                neg_reg <= num[M_W-1];
            end
            default: ;
        endcase
    end

    assign div_start = state_reg == ST_FSUM;

    mlc_div #(
        .NW(NW),
        .DW(S_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_num),
        .divisor (s_reg),
        .done    (div_done),
        .quotient(uq)
    );

    always_comb
    begin
        if (neg_reg)
        begin
            q_sat = uq > DMAX + NW'(1) ? DATA_WIDTH'(-(DMAX + NW'(1))) : DATA_WIDTH'(-uq);
        end
        else
        begin
            q_sat = uq > DMAX ? DATA_WIDTH'(DMAX) : DATA_WIDTH'(uq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            p_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        shift      = 1'b0;
        clear_acc  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_elem)
                begin
                    state_next = ST_ACC;
                    p_next     = '0;
                end
            end
            ST_ACC:
            begin
                shift  = p_reg >= PW'(2);
                p_next = p_reg + PW'(1);
                if (32'(p_reg) == MAX_HIDDEN + 1)
                begin
                    cnt_next = cnt_reg + CW'(1);
                    j_next   = '0;
                    state_next = (cnt_reg + CW'(1) >= nin) ? ST_FRD : ST_IDLE;
                end
            end
            ST_FRD:  state_next = ST_FZ;
            ST_FZ:   state_next = ST_FSIG;
            ST_FSIG: state_next = ST_FMUL;
            ST_FMUL: state_next = ST_FSUM;
            ST_FSUM: state_next = ST_FDIV;
            ST_FDIV:
            begin
                if (div_done)
                begin
                    shift  = 1'b1;
                    j_next = j_reg + JW'(1);
                    if (j_reg + JW'(1) < nh)
                    begin
                        state_next = ST_FRD;
                    end
                    else if (32'(j_reg) + 1 < MAX_HIDDEN)
                    begin
                        state_next = ST_SKIP;
                    end
                    else
                    begin
                        state_next = ST_CLR;
                    end
                end
            end
            ST_SKIP:
            begin
                shift  = 1'b1;
                j_next = j_reg + JW'(1);
                if (32'(j_reg) + 1 >= MAX_HIDDEN)
                begin
                    state_next = ST_CLR;
                end
            end
            ST_CLR:
            begin
                clear_acc  = 1'b1;
                cnt_next   = '0;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= state_reg == ST_FDIV && div_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FDIV && div_done)
        begin
            out_unit_reg <= UNIT_W'(j_reg);
            out_h_reg    <= q_sat;
            out_last_reg <= j_reg + JW'(1) == nh;
        end
    end

    assign result_valid = out_valid_reg;
    assign unit_index   = out_unit_reg;
    assign hidden_value = out_h_reg;
    assign last         = out_last_reg;

    a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside a vector finish");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("result after the final unit of a vector");

    a_div_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FDIV && div_done) |-> j_reg < nh)
        else $error("hidden update for a unit out of use");

endmodule

/* verif/minlstm_cell_forward_test.sv */
// Self-checking testbench for minlstm_cell_forward: a queue-fed command driver,
// a result monitor and an in-bench fixed-point model of the minLSTM cell.
// Depends on mlc_pkg and the minlstm_cell_forward RTL.
module minlstm_cell_forward_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mlc_pkg::*;

    localparam int NI = DEF_MAX_INPUT;
    localparam int NH = DEF_MAX_HIDDEN;
    localparam int NI_USE = 4;
    localparam int NH_USE = 4;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam logic [GATE_W-1:0] GATE_NONE = 2'd3;
    localparam int SETTLE = 100;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [GATE_W-1:0] gate;
        logic is_bias;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic signed [15:0] value;
        int gap;
    } word_t;

    typedef struct {
        logic [UNIT_W-1:0] unit;
        logic signed [15:0] hval;
        logic is_last;
    } hidden_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [MODE_W-1:0] mode = MODE_NONE;
    logic [GATE_W-1:0] gate = GATE_FORGET;
    logic is_bias = 1'b0;
    logic [ROW_W-1:0] row = '0;
    logic [COL_W-1:0] col = '0;
    logic signed [15:0] value = '0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_INPUT_LENGTH;
    logic [CFG_W-1:0] cfg_data = '0;
    logic result_valid;
    logic [UNIT_W-1:0] unit_index;
    logic signed [15:0] hidden_value;
    logic last;

    word_t pending_words[$];
    hidden_word_t hidden_expected[$];
    logic taken = 1'b0;
    int gap_left = 0;
    int held_gap = 0;
    int errors = 0;
    int quiet_cycles = 0;
    logic burst = 1'b0;

    logic signed [15:0] m_weight [3][NI][NH];
    logic signed [15:0] m_bias [3][NH];
    logic signed [15:0] m_hidden [NH];
    logic signed [ACC_W-1:0] m_proj [3][NH];
    logic [6:0] m_count = '0;
    logic [6:0] m_in_len = 7'd1;
    logic [6:0] m_hid_cnt = 7'd1;

    minlstm_cell_forward u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .gate(gate), .is_bias(is_bias), .row(row), .col(col),
        .value(value), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .unit_index(unit_index),
        .hidden_value(hidden_value), .last(last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp_len(logic [6:0] v);
        if (v == 0)
        begin
            return 1;
        end
        return (v > 64) ? 64 : int'(v);
    endfunction

    function automatic longint sigmoid(longint z);
        longint a;
        longint idx;
        longint y;
        if (z > 32767)
        begin
            z = 32767;
        end
        if (z < -32768)
        begin
            z = -32768;
        end
        a = (z < 0) ? -z : z;
        idx = a >> 11;
        if (idx >= SIG_LAST)
        begin
            y = SIG_TAB[SIG_LAST];
        end
        else
        begin
            y = SIG_TAB[idx] + (((SIG_TAB[idx + 1] - SIG_TAB[idx]) * (a & 2047)) >> 11);
        end
        return (z < 0) ? 32768 - y : y;
    endfunction

    task automatic emit_hidden();
        longint z [3];
        longint f;
        longint i;
        longint num;
        longint mag;
        longint s;
        longint uq;
        longint q;
        hidden_word_t hw;
        int nh;
        nh = clamp_len(m_hid_cnt);
        for (int j = 0; j < nh; j++)
        begin
            for (int g = 0; g < 3; g++)
            begin
                z[g] = (longint'(m_proj[g][j]) + (longint'(m_bias[g][j]) <<< FRAC)
                        + 2048) >>> FRAC;
            end
            f = sigmoid(z[0]);
            i = sigmoid(z[1]);
            num = f * longint'(m_hidden[j]) + i * z[2];
            s = f + i;
            mag = (num < 0) ? -num : num;
            uq = (mag + s / 2) / s;
            if (num < 0)
            begin
                q = (uq > 32768) ? -32768 : -uq;
            end
            else
            begin
                q = (uq > 32767) ? 32767 : uq;
            end
            m_hidden[j] = 16'(q);
            hw.unit = UNIT_W'(j);
            hw.hval = 16'(q);
            hw.is_last = (j + 1 == nh);
            hidden_expected.push_back(hw);
        end
        for (int g = 0; g < 3; g++)
        begin
            for (int j = 0; j < NH; j++)
            begin
                m_proj[g][j] = '0;
            end
        end
        m_count = '0;
    endtask

    task automatic apply_word();
        int nh;
        nh = clamp_len(m_hid_cnt);
        case (mode)
            MODE_LOAD:
            begin
                if (gate != GATE_NONE)
                begin
                    if (is_bias)
                    begin
                        m_bias[gate][col] = value;
                    end
                    else
                    begin
                        m_weight[gate][row][col] = value;
                    end
                end
            end
            MODE_CLEAR:
            begin
                for (int j = 0; j < NH; j++)
                begin
                    m_hidden[j] = '0;
                end
            end
            MODE_ELEM:
            begin
                if (m_count < NI)
                begin
                    for (int g = 0; g < 3; g++)
                    begin
                        for (int j = 0; j < nh; j++)
                        begin
                            m_proj[g][j] = m_proj[g][j]
                                + ACC_W'(longint'(value) * longint'(m_weight[g][m_count][j]));
                        end
                    end
                end
                m_count = m_count + 7'd1;
                if (m_count >= clamp_len(m_in_len))
                begin
                    emit_hidden();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        taken <= start && !busy;
        if (rst_n && start && !busy)
        begin
            apply_word();
        end
        if (cfg_we)
        begin
            if (cfg_index == REG_INPUT_LENGTH)
            begin
                m_in_len = cfg_data;
            end
            else
            begin
                m_hid_cnt = cfg_data;
            end
        end
        if (rst_n && result_valid)
        begin
            if (hidden_expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result unit %0d value %0d", $time,
                         unit_index, hidden_value);
            end
            else
            begin
                hidden_word_t hw;
                hw = hidden_expected.pop_front();
                if (unit_index !== hw.unit || hidden_value !== hw.hval
                    || last !== hw.is_last)
                begin
                    errors++;
                    $display("%0t: expected unit %0d value %0d last %0b, got %0d %0d %0b",
                             $time, hw.unit, hw.hval, hw.is_last,
                             unit_index, hidden_value, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("minlstm_cell_forward test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge clk)
    begin
        word_t w;
        logic go;
        go = 1'b0;
        if (start && !taken)
        begin
            go = 1'b1;
        end
        else if (rst_n)
        begin
            if (start)
            begin
                gap_left = held_gap;
            end
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_words.size() > 0)
            begin
                w = pending_words.pop_front();
                mode <= w.mode;
                gate <= w.gate;
                is_bias <= w.is_bias;
                row <= w.row;
                col <= w.col;
                value <= w.value;
                held_gap = w.gap;
                go = 1'b1;
            end
        end
        start <= go;
    end

    task automatic add_word(logic [MODE_W-1:0] m, logic [GATE_W-1:0] g, logic b,
                            int r, int c, int v);
        word_t w;
        w.mode = m;
        w.gate = g;
        w.is_bias = b;
        w.row = ROW_W'(r);
        w.col = COL_W'(c);
        w.value = 16'(v);
        if ($urandom_range(0, 9) == 0)
        begin
            burst = ~burst;
        end
        w.gap = burst ? 0 : $urandom_range(0, 14);
        pending_words.push_back(w);
    endtask

    function automatic int rand_value();
        if ($urandom_range(0, 1) == 0)
        begin
            return $urandom_range(0, 65535);
        end
        return $urandom_range(0, 4095) - 2048;
    endfunction

    task automatic wait_quiet();
        while (pending_words.size() > 0 || start || busy || hidden_expected.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int in_len, int hid_cnt, int n);
        int r;
        wait_quiet();
        write_reg(REG_INPUT_LENGTH, in_len);
        write_reg(REG_HIDDEN_COUNT, hid_cnt);
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                add_word(MODE_ELEM, GATE_FORGET, 1'b0, $urandom_range(0, 63),
                         $urandom_range(0, 63), rand_value());
            end
            else if (r < 88)
            begin
                add_word(MODE_LOAD, GATE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
            end
            else if (r < 95)
            begin
                add_word(MODE_CLEAR, GATE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
            end
            else
            begin
                add_word(MODE_NONE, GATE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
            end
        end
    endtask

    initial
    begin
        for (int j = 0; j < NH; j++)
        begin
            m_hidden[j] = '0;
            for (int g = 0; g < 3; g++)
            begin
                m_proj[g][j] = '0;
            end
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every parameter word is written before any element can read it.
        // Vector lengths and unit counts stay within the loaded rows and columns.
        for (int g = 0; g < 3; g++)
        begin
            add_word(MODE_LOAD, GATE_W'(g), 1'b1, 0, 0, 0);
            for (int c = 0; c < NH_USE; c++)
            begin
                add_word(MODE_LOAD, GATE_W'(g), 1'b1, $urandom_range(0, 63), c, rand_value());
                for (int r = 0; r < NI_USE; r++)
                begin
                    add_word(MODE_LOAD, GATE_W'(g), 1'b0, r, c, rand_value());
                end
            end
        end
        add_word(MODE_ELEM, GATE_FORGET, 1'b0, 0, 0, 32767);

        random_phase(3, 4, 0);
        add_word(MODE_LOAD, GATE_NONE, 1'b0, 5, 2, 16'h1234);
        add_word(MODE_LOAD, GATE_FORGET, 1'b1, 63, 1, 32767);
        add_word(MODE_LOAD, GATE_INPUT, 1'b1, 17, 2, -32768);
        add_word(MODE_LOAD, GATE_CAND, 1'b0, 0, 0, -32768);
        add_word(MODE_LOAD, GATE_CAND, 1'b0, 1, 3, 32767);
        add_word(MODE_NONE, GATE_CAND, 1'b1, 63, 63, -1);
        add_word(MODE_ELEM, GATE_FORGET, 1'b0, 0, 0, 32767);
        add_word(MODE_CLEAR, GATE_FORGET, 1'b0, 0, 0, 0);
        add_word(MODE_ELEM, GATE_FORGET, 1'b0, 0, 0, -32768);
        add_word(MODE_ELEM, GATE_FORGET, 1'b0, 0, 0, 0);
        add_word(MODE_ELEM, GATE_FORGET, 1'b0, 0, 0, 1);
        add_word(MODE_ELEM, GATE_FORGET, 1'b0, 0, 0, -1);

        // Shorten the vector while two elements are already counted.
        random_phase(1, 4, 0);
        add_word(MODE_ELEM, GATE_FORGET, 1'b0, 0, 0, 4096);
        random_phase(0, 0, 0);
        add_word(MODE_ELEM, GATE_FORGET, 1'b0, 0, 0, -4096);

        random_phase(2, 3, 25);
        random_phase(4, 4, 25);
        random_phase(1, 4, 15);
        random_phase(4, 2, 15);
        random_phase(3, 1, 15);
        random_phase($urandom_range(1, NI_USE), $urandom_range(1, NH_USE), 15);
        random_phase($urandom_range(1, NI_USE), $urandom_range(1, NH_USE), 15);

        wait_quiet();
        if (errors == 0)
        begin
            $display("minlstm_cell_forward test passed");
        end
        else
        begin
            $display("minlstm_cell_forward test failed");
        end
        $finish;
    end

endmodule
